// File: design/mi3_pkg.sv
// Shared types and constants for the 3x3 fixed-point matrix inverse.
// Holds the request/result structs, datapath widths and the cofactor operand map.
// No dependencies.
package mi3_pkg;

  localparam int unsigned ElemW = 32;   // Q16.16 element width
  localparam int unsigned ProdW = 64;   // product of two elements
  localparam int unsigned CofW  = 65;   // 2x2 cofactor, signed
  localparam int unsigned PartW = 65;   // element times half a cofactor
  localparam int unsigned DetW  = 97;   // determinant, signed
  localparam int unsigned MagW  = 96;   // magnitudes fed to the divider
  localparam int unsigned QuoW  = 32;   // quotient bits produced per lane
  localparam int unsigned NumEl = 9;

  localparam logic [ElemW-1:0] MaxPos = {1'b0, {(ElemW-1){1'b1}}};
  localparam logic [ElemW-1:0] MinNeg = {1'b1, {(ElemW-1){1'b0}}};

  // cofactor k = a[i0]*a[i1] - a[i2]*a[i3], laid out in adjugate (output) order
  localparam logic [3:0] CofIdx [NumEl][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd7, 4'd2, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  typedef logic [MagW-1:0] mag_t;

  typedef struct packed {
    logic signed [ElemW-1:0] m00;
    logic signed [ElemW-1:0] m01;
    logic signed [ElemW-1:0] m02;
    logic signed [ElemW-1:0] m10;
    logic signed [ElemW-1:0] m11;
    logic signed [ElemW-1:0] m12;
    logic signed [ElemW-1:0] m20;
    logic signed [ElemW-1:0] m21;
    logic signed [ElemW-1:0] m22;
  } in_t;

  typedef struct packed {
    logic signed [ElemW-1:0] inv00;
    logic signed [ElemW-1:0] inv01;
    logic signed [ElemW-1:0] inv02;
    logic signed [ElemW-1:0] inv10;
    logic signed [ElemW-1:0] inv11;
    logic signed [ElemW-1:0] inv12;
    logic signed [ElemW-1:0] inv20;
    logic signed [ElemW-1:0] inv21;
    logic signed [ElemW-1:0] inv22;
    logic                    singular;
    logic                    saturated;
  } out_t;

  // sign and singular marks that ride along the divider pipeline
  typedef struct packed {
    logic [NumEl-1:0] neg;
    logic             sing;
  } side_t;

endpackage

// File: design/matrix3x3_inverse.sv
// Top level of the 3x3 signed Q16.16 matrix inverse by the adjugate.
// Depends on mi3_pkg and mi3_div.
//
// Usage:
//   Request channel: drive req_i with the nine elements and pulse start; the
//   request is taken at each rising edge where start is high and busy is low.
//   busy never rises, so a new request can be taken in every cycle.
//   Result channel: done_o marks res_o for exactly one cycle, once the request
//   has passed through the pipeline below. Results leave in request order.
//   Pipeline: input register, 2x2 products, cofactors, row-0 partial products,
//   partial merge, determinant, magnitudes, then a nine-lane divider that
//   resolves one quotient bit per stage (33 stages), then saturation and sign.
//   The divider depth sets the latency; throughput is one matrix per cycle.
//   A zero determinant yields all-zero elements with singular set.
//   Quotients outside 32 bits clamp and set saturated.
//   Reset clears all valid bits; requests in flight are dropped.
//   The receiver cannot hold results off, so nothing in the pipe ever stalls.
module matrix3x3_inverse (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  mi3_pkg::in_t   req_i,
  output logic           done_o,
  output mi3_pkg::out_t  res_o
);

  localparam int unsigned NumEl = mi3_pkg::NumEl;
  localparam int unsigned ElemW = mi3_pkg::ElemW;
  localparam int unsigned MagW  = mi3_pkg::MagW;

  logic             take;
  logic [6:0]       vld_q;
  mi3_pkg::in_t     in_q;

  logic signed [ElemW-1:0]          a [NumEl];
  logic signed [mi3_pkg::ProdW-1:0] prod_q [2*NumEl];
  logic signed [ElemW-1:0]          row2_q [3];
  logic signed [ElemW-1:0]          row3_q [3];
  logic signed [mi3_pkg::CofW-1:0]  cof3_q [NumEl];
  logic signed [mi3_pkg::CofW-1:0]  cof4_q [NumEl];
  logic signed [mi3_pkg::CofW-1:0]  cof5_q [NumEl];
  logic signed [mi3_pkg::CofW-1:0]  cof6_q [NumEl];
  logic signed [mi3_pkg::PartW-1:0] lo_q [3];
  logic signed [mi3_pkg::PartW-1:0] hi_q [3];
  logic signed [mi3_pkg::DetW-1:0]  term_q [3];
  logic signed [mi3_pkg::DetW-1:0]  det_q;

  logic signed [mi3_pkg::CofW-1:0]  cabs [NumEl];
  logic signed [mi3_pkg::DetW-1:0]  dabs;
  mi3_pkg::mag_t [NumEl-1:0]        cmag_d, cmag_q;
  mi3_pkg::mag_t                    dmag_d, dmag_q;
  mi3_pkg::side_t                   side_d, side_q;

  logic                                   dv_valid;
  logic [NumEl-1:0][mi3_pkg::QuoW-1:0]    dv_quo;
  logic [NumEl-1:0]                       dv_ovf;
  mi3_pkg::side_t                         dv_side;

  logic [ElemW-1:0] val [NumEl];
  logic [NumEl-1:0] clamp;
  mi3_pkg::out_t    res_d, res_q;
  logic             done_q;

  assign busy = 1'b0;
  assign take = start & ~busy;

  assign a[0] = in_q.m00;
  assign a[1] = in_q.m01;
  assign a[2] = in_q.m02;
  assign a[3] = in_q.m10;
  assign a[4] = in_q.m11;
  assign a[5] = in_q.m12;
  assign a[6] = in_q.m20;
  assign a[7] = in_q.m21;
  assign a[8] = in_q.m22;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[5:0], take};
    end
  end

  // datapath stages advance every cycle; valid bits above say which hold work
  always_ff @(posedge clk_i) begin
    in_q <= req_i;
    for (int k = 0; k < NumEl; k++) begin
      prod_q[2*k]   <= a[mi3_pkg::CofIdx[k][0]] * a[mi3_pkg::CofIdx[k][1]];
      prod_q[2*k+1] <= a[mi3_pkg::CofIdx[k][2]] * a[mi3_pkg::CofIdx[k][3]];
      cof3_q[k]     <= prod_q[2*k] - prod_q[2*k+1];
      cof4_q[k]     <= cof3_q[k];
      cof5_q[k]     <= cof4_q[k];
      cof6_q[k]     <= cof5_q[k];
    end
    // det = a00*adj00 + a01*adj10 + a02*adj20, each cofactor split in halves
    for (int j = 0; j < 3; j++) begin
      row2_q[j] <= a[j];
      row3_q[j] <= row2_q[j];
      lo_q[j]   <= row3_q[j] * $signed({1'b0, cof3_q[3*j][31:0]});
      hi_q[j]   <= row3_q[j] * $signed(cof3_q[3*j][mi3_pkg::CofW-1:32]);
      term_q[j] <= $signed({hi_q[j], 32'b0}) + mi3_pkg::DetW'(lo_q[j]);
    end
    det_q  <= term_q[0] + term_q[1] + term_q[2];
    cmag_q <= cmag_d;
    dmag_q <= dmag_d;
    side_q <= side_d;
  end

  always_comb begin
    dabs        = det_q[mi3_pkg::DetW-1] ? -det_q : det_q;
    dmag_d      = dabs[MagW-1:0];
    side_d.sing = (det_q == '0);
    for (int k = 0; k < NumEl; k++) begin
      cabs[k]        = cof6_q[k][mi3_pkg::CofW-1] ? -cof6_q[k] : cof6_q[k];
      cmag_d[k]      = {{(MagW-64){1'b0}}, cabs[k][63:0]};
      side_d.neg[k]  = cof6_q[k][mi3_pkg::CofW-1] ^ det_q[mi3_pkg::DetW-1];
    end
  end

  mi3_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q[6]),
    .num_i   (cmag_q),
    .den_i   (dmag_q),
    .side_i  (side_q),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .ovf_o   (dv_ovf),
    .side_o  (dv_side)
  );

  // clamp to 32 bits: magnitude limit is 2^31 for negative, 2^31-1 otherwise
  always_comb begin
    for (int k = 0; k < NumEl; k++) begin
      clamp[k] = dv_ovf[k] |
                 (dv_quo[k][ElemW-1] & (~dv_side.neg[k] | (|dv_quo[k][ElemW-2:0])));
      if (dv_side.sing) begin
        val[k] = '0;
      end else if (clamp[k]) begin
        val[k] = dv_side.neg[k] ? mi3_pkg::MinNeg : mi3_pkg::MaxPos;
      end else begin
        val[k] = dv_side.neg[k] ? (-dv_quo[k]) : dv_quo[k];
      end
    end
    res_d.inv00     = val[0];
    res_d.inv01     = val[1];
    res_d.inv02     = val[2];
    res_d.inv10     = val[3];
    res_d.inv11     = val[4];
    res_d.inv12     = val[5];
    res_d.inv20     = val[6];
    res_d.inv21     = val[7];
    res_d.inv22     = val[8];
    res_d.singular  = dv_side.sing;
    res_d.saturated = ~dv_side.sing & (|clamp);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> ##41 done_o)
    else $error("request did not complete after the pipeline latency");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.singular |-> !res_o.saturated && res_o.inv00 == '0 &&
      res_o.inv11 == '0 && res_o.inv22 == '0)
    else $error("singular result carries nonzero data");

  a_sat_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.saturated |->
      res_o.inv00 == mi3_pkg::MaxPos || res_o.inv00 == mi3_pkg::MinNeg ||
      res_o.inv01 == mi3_pkg::MaxPos || res_o.inv01 == mi3_pkg::MinNeg ||
      res_o.inv02 == mi3_pkg::MaxPos || res_o.inv02 == mi3_pkg::MinNeg ||
      res_o.inv10 == mi3_pkg::MaxPos || res_o.inv10 == mi3_pkg::MinNeg ||
      res_o.inv11 == mi3_pkg::MaxPos || res_o.inv11 == mi3_pkg::MinNeg ||
      res_o.inv12 == mi3_pkg::MaxPos || res_o.inv12 == mi3_pkg::MinNeg ||
      res_o.inv20 == mi3_pkg::MaxPos || res_o.inv20 == mi3_pkg::MinNeg ||
      res_o.inv21 == mi3_pkg::MaxPos || res_o.inv21 == mi3_pkg::MinNeg ||
      res_o.inv22 == mi3_pkg::MaxPos || res_o.inv22 == mi3_pkg::MinNeg)
    else $error("saturated flag without a clamped element");
`endif

endmodule

// File: design/mi3_div.sv
// Nine-lane pipelined restoring divider, one quotient bit per stage.
// Depends on mi3_pkg. Numerators are cofactor magnitudes, implicitly shifted left by 32.
module mi3_div (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  input  mi3_pkg::mag_t [mi3_pkg::NumEl-1:0]     num_i,
  input  mi3_pkg::mag_t                          den_i,
  input  mi3_pkg::side_t                         side_i,
  output logic                                   valid_o,
  output logic [mi3_pkg::NumEl-1:0][mi3_pkg::QuoW-1:0] quo_o,
  output logic [mi3_pkg::NumEl-1:0]              ovf_o,
  output mi3_pkg::side_t                         side_o
);

  localparam int unsigned Steps = mi3_pkg::QuoW;
  localparam int unsigned MagW  = mi3_pkg::MagW;
  localparam int unsigned NumEl = mi3_pkg::NumEl;

  logic [Steps:0]           vld_q;
  mi3_pkg::mag_t            rem_q [Steps+1][NumEl];
  logic [mi3_pkg::QuoW-1:0] quo_q [Steps+1][NumEl];
  mi3_pkg::mag_t            den_q [Steps+1];
  logic [NumEl-1:0]         ovf_q [Steps+1];
  mi3_pkg::side_t           side_q [Steps+1];

  // entry stage: quotient of 2^32 or more shows up as num >= den
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumEl; k++) begin
      rem_q[0][k]  <= num_i[k];
      quo_q[0][k]  <= '0;
      ovf_q[0][k]  <= (num_i[k] >= den_i);
    end
    den_q[0]  <= den_i;
    side_q[0] <= side_i;
  end

  for (genvar s = 1; s <= Steps; s++) begin : g_step
    logic [MagW:0]            two [NumEl];
    logic [NumEl-1:0]         ge;
    mi3_pkg::mag_t            rem_d [NumEl];
    logic [mi3_pkg::QuoW-1:0] quo_d [NumEl];

    always_comb begin
      for (int k = 0; k < NumEl; k++) begin
        two[k]   = {rem_q[s-1][k], 1'b0};
        ge[k]    = (two[k] >= {1'b0, den_q[s-1]});
        rem_d[k] = ge[k] ? MagW'(two[k] - {1'b0, den_q[s-1]}) : two[k][MagW-1:0];
        quo_d[k] = {quo_q[s-1][k][mi3_pkg::QuoW-2:0], ge[k]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      for (int k = 0; k < NumEl; k++) begin
        rem_q[s][k] <= rem_d[k];
        quo_q[s][k] <= quo_d[k];
      end
      den_q[s]  <= den_q[s-1];
      ovf_q[s]  <= ovf_q[s-1];
      side_q[s] <= side_q[s-1];
    end
  end

  assign valid_o = vld_q[Steps];
  assign ovf_o   = ovf_q[Steps];
  assign side_o  = side_q[Steps];
  always_comb begin
    for (int k = 0; k < NumEl; k++) begin
      quo_o[k] = quo_q[Steps][k];
    end
  end

endmodule
